@@ hw/rtl/bbcl_pkg.sv @@
// Types and constants shared by the buffer cache tag store.
package bbcl_pkg;

   // Bucket numbers are kept in this many bits per buffer (up to 64 buckets)
   localparam int BUCKET_W = 6;

   // Block number modulo: bits folded in per cycle and cycles per block number
   localparam int MOD_STEP   = 4;
   localparam int MOD_CYCLES = 32 / MOD_STEP;

   localparam logic [7:0] COUNT_MAX = 8'hff;

   localparam logic [1:0] OP_READ    = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_PIN     = 2'd2;
   localparam logic [1:0] OP_UNPIN   = 2'd3;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_MISS      = 2'd1;
   localparam logic [1:0] ST_NOFREE    = 2'd2;
   localparam logic [1:0] ST_UNDERFLOW = 2'd3;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  device_id;
      logic [31:0] block_number;
      logic [4:0]  buffer_index;
      logic [31:0] current_tick;
   } req_payload_type;

   typedef struct packed {
      logic [4:0] granted_buffer;
      logic       needs_disk_read;
      logic [1:0] status;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0]          device;
      logic [31:0]         block;
      logic [BUCKET_W-1:0] bucket;
      logic [7:0]          count;
      logic [31:0]         tick;
      logic                valid;
   } entry_type;

endpackage

@@ hw/rtl/block_buffer_cache_lru_unit.sv @@
// Buffer cache tag store with reference counts, hashed buckets and LRU victim choice.

// One transaction at a time. A read lookup first folds the block number into its
// bucket, 4 bits a cycle through a single remainder unit. Next, it sweeps the tag
// memory one buffer a cycle through its single read port to find a hit and the best
// free victim. Last, it reads the chosen entry again, writes it back when a buffer is
// granted and loads the response. Release, pin and unpin read the indexed entry and
// write it back unless the count would underflow; an index beyond the last buffer
// answers without touching the tag memory. Each buffer's bucket is stored with its
// tag, so the sweep needs no division. A finished response sits in an output
// register while the next transaction is accepted. A response that is still held there
// because rsp_ready is low stalls the following one until it leaves.
module block_buffer_cache_lru_unit #(
   parameter int NUM_BUFFERS = 32,
   parameter int NUM_BUCKETS = 13
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  bbcl_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bbcl_pkg::rsp_payload_type rsp_data
);
   import bbcl_pkg::*;

   localparam int IW  = $clog2(NUM_BUFFERS);
   localparam int CW  = IW + 1;
   localparam int DW  = BUCKET_W + 1;
   localparam int MCW = $clog2(MOD_CYCLES);
   localparam logic [CW-1:0]  ENTRIES  = CW'(NUM_BUFFERS);
   localparam logic [DW-1:0]  BUCKETS  = DW'(NUM_BUCKETS);
   localparam logic [MCW-1:0] MOD_LAST = MCW'(MOD_CYCLES - 1);
   localparam logic [8:0]     IDX_LIMIT = 9'(NUM_BUFFERS);

   typedef enum logic [2:0] {
      S_IDLE, S_MOD, S_SCAN, S_DECIDE, S_APPLY, S_FETCH, S_RESP
   } state_type;

   state_type           state_ff, state_in;
   req_payload_type     req_ff, req_in;
   logic [BUCKET_W-1:0] rem_ff, rem_in;
   logic [31:0]         shift_ff, shift_in;
   logic [MCW-1:0]      mod_cnt_ff, mod_cnt_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                issue_ff, issue_in;
   logic                hit_found_ff, hit_found_in;
   logic [IW-1:0]       hit_idx_ff, hit_idx_in;
   logic                vic_found_ff, vic_found_in;
   logic [IW-1:0]       vic_idx_ff, vic_idx_in;
   logic [DW-1:0]       vic_dist_ff, vic_dist_in;
   logic [31:0]         vic_tick_ff, vic_tick_in;
   rsp_payload_type     res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_data_ff, rsp_data_in;
   logic [NUM_BUFFERS-1:0] written_ff, written_in;

   // tag memory with registered read
   entry_type           tag_mem_ff [NUM_BUFFERS];
   entry_type           rd_entry_ff;
   logic                rd_ok_ff;
   logic [IW-1:0]       rd_idx_ff;

   logic [IW-1:0]       rd_addr;
   logic                mem_we;
   logic [IW-1:0]       mem_wa;
   entry_type           mem_wd;
   entry_type           cur;
   logic [DW-1:0]       mod_acc;
   logic [DW-1:0]       gap;
   logic                match;
   logic                better;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // never-written entries read as the reset contents
   assign cur = rd_ok_ff ? rd_entry_ff : '0;

   always_comb begin
      unique case (state_ff)
         S_SCAN:   rd_addr = cnt_ff[IW-1:0];
         S_DECIDE: rd_addr = hit_found_ff ? hit_idx_ff : vic_idx_ff;
         default:  rd_addr = IW'(req_data.buffer_index);
      endcase
   end

   // remainder unit: fold MOD_STEP bits of the block number per cycle
   always_comb begin
      mod_acc = {1'b0, rem_ff};
      for (int k = 0; k < MOD_STEP; k++) begin
         mod_acc = {mod_acc[DW-2:0], shift_ff[31-k]};
         if (mod_acc >= BUCKETS) begin
            mod_acc = mod_acc - BUCKETS;
         end
      end
   end

   // circular distance from the requested bucket, plus ordering of candidates
   always_comb begin
      if ({1'b0, cur.bucket} >= {1'b0, rem_ff}) begin
         gap = {1'b0, cur.bucket} - {1'b0, rem_ff};
      end else begin
         gap = {1'b0, cur.bucket} + BUCKETS - {1'b0, rem_ff};
      end
      match  = (cur.device == req_ff.device_id) && (cur.block == req_ff.block_number);
      better = !vic_found_ff || (gap < vic_dist_ff) ||
               ((gap == vic_dist_ff) && (cur.tick < vic_tick_ff));
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rem_in       = rem_ff;
      shift_in     = shift_ff;
      mod_cnt_in   = mod_cnt_ff;
      cnt_in       = cnt_ff;
      issue_in     = issue_ff;
      hit_found_in = hit_found_ff;
      hit_idx_in   = hit_idx_ff;
      vic_found_in = vic_found_ff;
      vic_idx_in   = vic_idx_ff;
      vic_dist_in  = vic_dist_ff;
      vic_tick_in  = vic_tick_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      written_in   = written_ff;
      mem_we       = 1'b0;
      mem_wa       = rd_idx_ff;
      mem_wd       = cur;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               if (req_data.operation == OP_READ) begin
                  rem_in     = '0;
                  shift_in   = req_data.block_number;
                  mod_cnt_in = '0;
                  state_in   = S_MOD;
               end else if (9'(req_data.buffer_index) < IDX_LIMIT) begin
                  state_in = S_FETCH;
               end else begin
                  res_in.granted_buffer  = req_data.buffer_index;
                  res_in.needs_disk_read = 1'b0;
                  res_in.status          = ST_DONE;
                  state_in               = S_RESP;
               end
            end
         end
         S_MOD: begin
            rem_in     = mod_acc[BUCKET_W-1:0];
            shift_in   = shift_ff << MOD_STEP;
            mod_cnt_in = mod_cnt_ff + 1'b1;
            if (mod_cnt_ff == MOD_LAST) begin
               cnt_in       = '0;
               issue_in     = 1'b0;
               hit_found_in = 1'b0;
               vic_found_in = 1'b0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            issue_in = 1'b0;
            if (issue_ff) begin
               if (match && !hit_found_ff) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = rd_idx_ff;
               end
               if ((cur.count == 8'd0) && better) begin
                  vic_found_in = 1'b1;
                  vic_idx_in   = rd_idx_ff;
                  vic_dist_in  = gap;
                  vic_tick_in  = cur.tick;
               end
            end
            if (cnt_ff != ENTRIES) begin
               issue_in = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
            end else if (!issue_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            state_in = S_RESP;
            if (hit_found_ff) begin
               mem_we       = 1'b1;
               mem_wd.valid = 1'b1;
               if (cur.count != COUNT_MAX) begin
                  mem_wd.count = cur.count + 8'd1;
               end
               res_in.granted_buffer  = 5'(rd_idx_ff);
               res_in.needs_disk_read = ~cur.valid;
               res_in.status          = ST_DONE;
            end else if (vic_found_ff) begin
               mem_we        = 1'b1;
               mem_wd.device = req_ff.device_id;
               mem_wd.block  = req_ff.block_number;
               mem_wd.bucket = rem_ff;
               mem_wd.count  = 8'd1;
               mem_wd.tick   = req_ff.current_tick;
               mem_wd.valid  = 1'b1;
               res_in.granted_buffer  = 5'(rd_idx_ff);
               res_in.needs_disk_read = 1'b1;
               res_in.status          = ST_MISS;
            end else begin
               res_in.granted_buffer  = '0;
               res_in.needs_disk_read = 1'b0;
               res_in.status          = ST_NOFREE;
            end
         end
         S_FETCH: begin
            state_in               = S_RESP;
            res_in.granted_buffer  = req_ff.buffer_index;
            res_in.needs_disk_read = 1'b0;
            res_in.status          = ST_DONE;
            case (req_ff.operation) inside
               OP_PIN: begin
                  mem_we = 1'b1;
                  if (cur.count != COUNT_MAX) begin
                     mem_wd.count = cur.count + 8'd1;
                  end
               end
               OP_RELEASE, OP_UNPIN: begin
                  if (cur.count == 8'd0) begin
                     res_in.status = ST_UNDERFLOW;
                  end else begin
                     mem_we       = 1'b1;
                     mem_wd.count = cur.count - 8'd1;
                     // stamp the free time when a release drops the last reference
                     if ((req_ff.operation == OP_RELEASE) && (cur.count == 8'd1)) begin
                        mem_wd.tick = req_ff.current_tick;
                     end
                  end
               end
               default: begin
                  mem_we = 1'b0;
               end
            endcase
         end
         S_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (mem_we) begin
         written_in[mem_wa] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         issue_ff     <= 1'b0;
         written_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         issue_ff     <= issue_in;
         written_ff   <= written_in;
      end
      req_ff       <= req_in;
      rem_ff       <= rem_in;
      shift_ff     <= shift_in;
      mod_cnt_ff   <= mod_cnt_in;
      cnt_ff       <= cnt_in;
      hit_found_ff <= hit_found_in;
      hit_idx_ff   <= hit_idx_in;
      vic_found_ff <= vic_found_in;
      vic_idx_ff   <= vic_idx_in;
      vic_dist_ff  <= vic_dist_in;
      vic_tick_ff  <= vic_tick_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
      rd_ok_ff     <= written_ff[rd_addr];
      rd_idx_ff    <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem_ff[mem_wa] <= mem_wd;
      end
      rd_entry_ff <= tag_mem_ff[rd_addr];
   end

endmodule

@@ tb/grant_check_pkg.sv @@
`timescale 1ns / 1ps
// Predictor and scoreboard for the buffer cache tag store responses.
package grant_check_pkg;
   import bbcl_pkg::*;

   localparam int BUFFERS      = 32;
   localparam int BUCKETS      = 13;
   localparam int REPORT_LIMIT = 10;

   class grant_scoreboard;
      bit [7:0]  tag_device     [BUFFERS];
      bit [31:0] tag_block      [BUFFERS];
      bit [7:0]  ref_count      [BUFFERS];
      bit [31:0] free_tick      [BUFFERS];
      bit        contents_valid [BUFFERS];
      rsp_payload_type expected_grants [$];
      int unsigned failures;

      function int pending();
         return expected_grants.size();
      endfunction

      // Random buffer that currently holds references, or -1 when none does.
      function int pick_held();
         int held [$];
         int i;
         for (i = 0; i < BUFFERS; i++) begin
            if (ref_count[i] != 0) held.push_back(i);
         end
         if (held.size() == 0) return -1;
         return held[$urandom_range(0, held.size() - 1)];
      endfunction

      function void note_request(req_payload_type item);
         rsp_payload_type grant;
         int unsigned slot;
         int unsigned start;
         int unsigned bk;
         int k;
         int i;
         int victim;
         grant = '0;
         if (item.operation == OP_READ) begin
            victim = -1;
            for (i = 0; i < BUFFERS; i++) begin
               if (victim < 0 && tag_device[i] == item.device_id &&
                   tag_block[i] == item.block_number) victim = i;
            end
            if (victim >= 0) begin
               if (ref_count[victim] != COUNT_MAX) ref_count[victim]++;
               grant.status = ST_DONE;
            end else begin
               // walk buckets upward from the requested one, oldest free buffer wins
               start = item.block_number % BUCKETS;
               for (k = 0; k < BUCKETS && victim < 0; k++) begin
                  bk = (start + k) % BUCKETS;
                  for (i = 0; i < BUFFERS; i++) begin
                     if (ref_count[i] == 0 && tag_block[i] % BUCKETS == bk) begin
                        if (victim < 0 || free_tick[i] < free_tick[victim]) victim = i;
                     end
                  end
               end
               if (victim < 0) begin
                  grant.status = ST_NOFREE;
               end else begin
                  tag_device[victim]     = item.device_id;
                  tag_block[victim]      = item.block_number;
                  ref_count[victim]      = 8'd1;
                  free_tick[victim]      = item.current_tick;
                  contents_valid[victim] = 1'b0;
                  grant.status           = ST_MISS;
               end
            end
            if (victim >= 0) begin
               grant.granted_buffer  = 5'(victim);
               grant.needs_disk_read = !contents_valid[victim];
               contents_valid[victim] = 1'b1;
            end
         end else begin
            slot = 32'(item.buffer_index);
            grant.granted_buffer = item.buffer_index;
            grant.status = ST_DONE;
            if (slot < BUFFERS) begin
               if (item.operation == OP_PIN) begin
                  if (ref_count[slot] != COUNT_MAX) ref_count[slot]++;
               end else if (ref_count[slot] == 0) begin
                  grant.status = ST_UNDERFLOW;
               end else begin
                  ref_count[slot]--;
                  if (item.operation == OP_RELEASE && ref_count[slot] == 0)
                     free_tick[slot] = item.current_tick;
               end
            end
         end
         expected_grants.push_back(grant);
      endfunction

      function void check_grant(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_grants.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("ERROR %0t: unexpected response: buffer %0d read %0b status %0d",
                        $time, got.granted_buffer, got.needs_disk_read, got.status);
            return;
         end
         want = expected_grants.pop_front();
         if (got.granted_buffer !== want.granted_buffer ||
             got.needs_disk_read !== want.needs_disk_read ||
             got.status !== want.status) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("ERROR %0t: want buffer %0d read %0b status %0d, got %0d %0b %0d",
                        $time, want.granted_buffer, want.needs_disk_read, want.status,
                        got.granted_buffer, got.needs_disk_read, got.status);
         end
      endfunction
   endclass

endpackage

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Top-level testbench for the buffer cache tag store: directed and random traffic with stalls.
module tb;
   import bbcl_pkg::*;
   import grant_check_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 600_000;
   localparam int unsigned RANDOM_ITEMS = 1400;
   localparam int unsigned QUIET_ITEMS  = 200;
   localparam int unsigned DRAIN_CYCLES = 64;
   localparam int unsigned CHUNK_ITEMS  = 40;

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;

   grant_scoreboard board;
   int unsigned     items_sent  = 0;
   int unsigned     cycles      = 0;
   logic            quiet_tail  = 1'b0;
   bit              sender_gaps = 1'b1;
   bit [31:0]       tick_now    = '0;

   always #5 clock = ~clock;

   block_buffer_cache_lru_unit #(
      .NUM_BUFFERS(BUFFERS),
      .NUM_BUCKETS(BUCKETS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // Present one transaction, hold it until accepted, then record it.
   task automatic send_request(input logic [1:0] op, input logic [7:0] dev,
                               input logic [31:0] blk, input logic [4:0] idx,
                               input logic [31:0] tick);
      req_payload_type item;
      item.operation    = op;
      item.device_id    = dev;
      item.block_number = blk;
      item.buffer_index = idx;
      item.current_tick = tick;
      if (sender_gaps && !quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      board.note_request(item);
      items_sent++;
   endtask

   function automatic logic [4:0] target_index();
      int held;
      held = board.pick_held();
      if (held >= 0 && $urandom_range(0, 7) != 0) return 5'(held);
      return 5'($urandom_range(0, BUFFERS - 1));
   endfunction

   // One random transaction; fill mode leans toward taking references, drain toward dropping.
   task automatic send_random(input bit fill);
      int unsigned roll;
      int unsigned read_pct;
      int unsigned release_pct;
      int unsigned pin_pct;
      logic [7:0]  dev;
      logic [31:0] blk;
      read_pct    = fill ? 55 : 25;
      release_pct = fill ? 20 : 45;
      pin_pct     = fill ? 15 : 5;
      if ($urandom_range(0, 39) == 0) tick_now = $urandom();
      else tick_now = tick_now + $urandom_range(0, 50);
      roll = $urandom_range(0, 99);
      if (roll < read_pct) begin
         if ($urandom_range(0, 9) < 7) begin
            dev = 8'($urandom_range(0, 2));
            blk = $urandom_range(0, 60);
         end else begin
            dev = 8'($urandom());
            blk = $urandom();
         end
         send_request(OP_READ, dev, blk, 5'($urandom()), tick_now);
      end else if (roll < read_pct + release_pct) begin
         send_request(OP_RELEASE, 8'($urandom()), $urandom(), target_index(), tick_now);
      end else if (roll < read_pct + release_pct + pin_pct) begin
         send_request(OP_PIN, 8'($urandom()), $urandom(), target_index(), tick_now);
      end else begin
         send_request(OP_UNPIN, 8'($urandom()), $urandom(), target_index(), tick_now);
      end
   endtask

   // Drive one count past saturation, look it up at the ceiling, then unwind past zero.
   task automatic saturate_count();
      int b;
      b = $urandom_range(0, BUFFERS - 1);
      repeat (258) send_request(OP_PIN, 8'($urandom()), $urandom(), 5'(b), tick_now);
      send_request(OP_READ, board.tag_device[b], board.tag_block[b], 5'($urandom()),
                   tick_now);
      repeat (258) send_request(OP_UNPIN, 8'($urandom()), $urandom(), 5'(b), tick_now);
   endtask

   // Pin every free buffer, miss a few times with nothing free, then unpin.
   task automatic exhaust_buffers();
      int pinned [$];
      int i;
      for (i = 0; i < BUFFERS; i++) begin
         if (board.ref_count[i] == 0) begin
            pinned.push_back(i);
            send_request(OP_PIN, 8'($urandom()), $urandom(), 5'(i), tick_now);
         end
      end
      repeat (3) send_request(OP_READ, 8'($urandom()), $urandom(), 5'($urandom()), tick_now);
      foreach (pinned[i]) begin
         tick_now = tick_now + $urandom_range(1, 9);
         send_request(OP_UNPIN, 8'($urandom()), $urandom(), 5'(pinned[i]), tick_now);
      end
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("block_buffer_cache_lru_unit verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_grant(rsp_data);
   end

   // Response side backpressure: random stall bursts, long open stretches, none at the tail.
   initial begin
      do @(posedge clock); while (reset);
      forever begin
         if (!quiet_tail && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 7) == 0) repeat (200) @(posedge clock);
         else repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   initial begin
      int unsigned target;
      int unsigned chunk;
      bit          fill;
      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset tags: every buffer holds device 0 block 0, lowest index wins
      send_request(OP_READ, 8'h00, 32'h0000_0000, 5'd31, 32'd1);
      send_request(OP_READ, 8'h00, 32'h0000_0000, 5'd0, 32'd2);
      send_request(OP_RELEASE, 8'hff, 32'hffff_ffff, 5'd0, 32'hffff_ffff);
      send_request(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd0, 32'd5);
      send_request(OP_UNPIN, 8'h00, 32'h0000_0000, 5'd31, 32'd0);
      send_request(OP_PIN, 8'h00, 32'h0000_0000, 5'd31, 32'd6);
      send_request(OP_UNPIN, 8'h00, 32'h0000_0000, 5'd31, 32'd7);
      send_request(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd31, 32'd8);
      // miss from bucket 8 wraps to bucket zero, takes buffer 1
      send_request(OP_READ, 8'hff, 32'hffff_ffff, 5'd0, 32'hffff_ffff);
      send_request(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd1, 32'hffff_ffff);
      // only free buffer in that bucket carries the maximum tick
      send_request(OP_READ, 8'h05, 32'd8, 5'd17, 32'd10);
      send_request(OP_READ, 8'h05, 32'd8, 5'd17, 32'd10);
      send_request(OP_READ, 8'h00, 32'd13, 5'd3, 32'd11);
      send_request(OP_READ, 8'h00, 32'h0000_0000, 5'd3, 32'd12);
      send_request(OP_PIN, 8'h00, 32'h0000_0000, 5'd2, 32'd13);
      send_request(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd2, 32'd14);
      send_request(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd2, 32'd15);
      send_request(OP_UNPIN, 8'h00, 32'h0000_0000, 5'd1, 32'd16);
      send_request(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd1, 32'd17);
      send_request(OP_READ, 8'haa, 32'h5555_5555, 5'd21, 32'haaaa_aaaa);
      send_request(OP_READ, 8'h55, 32'haaaa_aaaa, 5'd10, 32'h5555_5555);
      send_request(OP_PIN, 8'hff, 32'hffff_ffff, 5'd0, 32'd18);
      tick_now = 32'd100;

      target = items_sent + RANDOM_ITEMS;
      chunk = 0;
      while (items_sent < target) begin
         if (items_sent + QUIET_ITEMS >= target) quiet_tail <= 1'b1;
         if (chunk == 3 || chunk == 14) begin
            exhaust_buffers();
         end else if (chunk == 7) begin
            saturate_count();
         end else begin
            fill = 1'($urandom_range(0, 1));
            sender_gaps = $urandom_range(0, 2) != 0;
            repeat (CHUNK_ITEMS) send_random(fill);
         end
         chunk++;
      end
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0)
         $display("block_buffer_cache_lru_unit verification clean");
      else
         $display("block_buffer_cache_lru_unit verification failed");
      $finish;
   end

endmodule

@@ block_buffer_cache_lru_unit.f @@
hw/rtl/bbcl_pkg.sv
hw/rtl/block_buffer_cache_lru_unit.sv
tb/grant_check_pkg.sv
tb/tb.sv
